### rtl/fxa_pkg.sv
// Shared types and constants for the signed fixed-point ALU.
// No dependencies; used by every module of the block.
package fxa_pkg;

    // Operand and result word width at the ports
    localparam int OPW = 32;
    // Internal working width: holds a full product and a shifted dividend with sign
    localparam int EW  = 66;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_DIV  = 4'd3,
        OP_EQ   = 4'd4,
        OP_NE   = 4'd5,
        OP_LT   = 4'd6,
        OP_GT   = 4'd7,
        OP_LE   = 4'd8,
        OP_GE   = 4'd9,
        OP_MIN  = 4'd10,
        OP_MAX  = 4'd11,
        OP_INC  = 4'd12,
        OP_DEC  = 4'd13,
        OP_FINT = 4'd14,
        OP_TINT = 4'd15
    } alu_op_t;

    // Control travelling alongside each request through the pipe
    typedef struct packed {
        logic valid;
        logic is_div;
        logic div_zero;
        logic neg;
        logic check;
        logic cond;
    } ctl_t;

endpackage

### rtl/fxa_front.sv
// Issue stage: decodes a request, does every non-divide operation and
// prepares the divide magnitudes. Depends on fxa_pkg.
module fxa_front #(
    parameter int FRAC_BITS = 8,
    parameter int WORD_BITS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          s_valid,
    input  logic [3:0]                    s_cmd,
    input  logic signed [fxa_pkg::OPW-1:0] s_operand_a,
    input  logic signed [fxa_pkg::OPW-1:0] s_operand_b,
    output fxa_pkg::ctl_t                 ctl_reg,
    output logic signed [fxa_pkg::EW-1:0] r_reg,
    output logic [fxa_pkg::OPW+FRAC_BITS-1:0] dq_reg,
    output logic [fxa_pkg::OPW-1:0]       dvs_reg
);
    import fxa_pkg::*;

    localparam int QW = OPW + FRAC_BITS;
    localparam logic signed [EW-1:0] WMAX = (EW'(1) <<< (WORD_BITS - 1)) - EW'(1);
    localparam logic signed [EW-1:0] WMIN = -WMAX - EW'(1);

    alu_op_t                 op;
    logic signed [EW-1:0]    a_e, b_e, prod_e, r_next;
    logic signed [2*OPW-1:0] prod;
    logic [OPW-1:0]          amag, bmag;
    ctl_t                    ctl_next;

    assign op = alu_op_t'(s_cmd);

    // Operation decode and datapath
    always_comb begin
        a_e    = {{(EW-OPW){s_operand_a[OPW-1]}}, s_operand_a};
        b_e    = {{(EW-OPW){s_operand_b[OPW-1]}}, s_operand_b};
        prod   = s_operand_a * s_operand_b;
        prod_e = {{(EW-2*OPW){prod[2*OPW-1]}}, prod};
        amag   = s_operand_a[OPW-1] ? OPW'(-s_operand_a) : OPW'(s_operand_a);
        bmag   = s_operand_b[OPW-1] ? OPW'(-s_operand_b) : OPW'(s_operand_b);
        r_next = '0;
        ctl_next          = '0;
        ctl_next.valid    = s_valid;
        ctl_next.neg      = s_operand_a[OPW-1] ^ s_operand_b[OPW-1];
        ctl_next.div_zero = (s_operand_b == '0);
        unique case (op)
            OP_ADD: begin
                r_next = a_e + b_e;
                ctl_next.check = 1'b1;
            end
            OP_SUB: begin
                r_next = a_e - b_e;
                ctl_next.check = 1'b1;
            end
            OP_MUL: begin
                r_next = prod_e >>> FRAC_BITS;
                ctl_next.check = 1'b1;
            end
            OP_DIV: begin
                r_next = a_e;
                ctl_next.is_div = 1'b1;
            end
            OP_EQ:  ctl_next.cond = (a_e == b_e);
            OP_NE:  ctl_next.cond = (a_e != b_e);
            OP_LT:  ctl_next.cond = (a_e <  b_e);
            OP_GT:  ctl_next.cond = (a_e >  b_e);
            OP_LE:  ctl_next.cond = (a_e <= b_e);
            OP_GE:  ctl_next.cond = (a_e >= b_e);
            OP_MIN: r_next = (a_e > b_e) ? b_e : a_e;
            OP_MAX: r_next = (a_e > b_e) ? a_e : b_e;
            OP_INC: r_next = (a_e >= WMAX) ? WMIN : a_e + EW'(1);
            OP_DEC: r_next = (a_e <= WMIN) ? WMAX : a_e - EW'(1);
            OP_FINT: begin
                r_next = a_e <<< FRAC_BITS;
                ctl_next.check = 1'b1;
            end
            OP_TINT: r_next = a_e >>> FRAC_BITS;
            default: r_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg   <= r_next;
            dq_reg  <= {amag, {FRAC_BITS{1'b0}}};
            dvs_reg <= bmag;
        end
    end

endmodule

### rtl/fxa_div_cell.sv
// One restoring-division cell: produces one quotient bit per request.
// Depends on fxa_pkg.
module fxa_div_cell #(
    parameter int QW = 40
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  fxa_pkg::ctl_t                  ctl_in,
    input  logic signed [fxa_pkg::EW-1:0]  r_in,
    input  logic [QW-1:0]                  dq_in,
    input  logic [fxa_pkg::OPW-1:0]        dvs_in,
    input  logic [fxa_pkg::OPW-1:0]        rem_in,
    output fxa_pkg::ctl_t                  ctl_reg,
    output logic signed [fxa_pkg::EW-1:0]  r_reg,
    output logic [QW-1:0]                  dq_reg,
    output logic [fxa_pkg::OPW-1:0]        dvs_reg,
    output logic [fxa_pkg::OPW-1:0]        rem_reg
);
    import fxa_pkg::*;

    logic [OPW:0]   trial;
    logic           qbit;
    logic [OPW-1:0] rem_next;

    // Shift in the next dividend bit and try the subtraction
    always_comb begin
        trial    = {rem_in, dq_in[QW-1]};
        qbit     = (trial >= {1'b0, dvs_in});
        rem_next = qbit ? OPW'(trial - {1'b0, dvs_in}) : OPW'(trial);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg   <= r_in;
            dq_reg  <= {dq_in[QW-2:0], qbit};
            dvs_reg <= dvs_in;
            rem_reg <= rem_next;
        end
    end

endmodule

### rtl/fxa_back.sv
// Retire stage: applies the quotient sign, range-checks and holds the
// output register. Depends on fxa_pkg.
module fxa_back #(
    parameter int FRAC_BITS = 8,
    parameter int WORD_BITS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  fxa_pkg::ctl_t                       ctl_in,
    input  logic signed [fxa_pkg::EW-1:0]       r_in,
    input  logic [fxa_pkg::OPW+FRAC_BITS-1:0]   dq_in,
    output logic                                m_valid,
    output logic signed [fxa_pkg::OPW-1:0]      m_result,
    output logic                                m_cond,
    output logic                                m_overflow
);
    import fxa_pkg::*;

    localparam int QW = OPW + FRAC_BITS;
    localparam logic signed [EW-1:0] WMAX = (EW'(1) <<< (WORD_BITS - 1)) - EW'(1);
    localparam logic signed [EW-1:0] WMIN = -WMAX - EW'(1);

    logic signed [EW-1:0] q_e, r_sel;
    logic                 chk, ovf;
    logic                 m_valid_reg, m_cond_reg, m_overflow_reg;
    logic signed [OPW-1:0] m_result_reg;

    // Pick the quotient for a divide, then check the word range
    always_comb begin
        q_e   = EW'(dq_in);
        q_e   = ctl_in.neg ? -q_e : q_e;
        r_sel = (ctl_in.is_div && !ctl_in.div_zero) ? q_e : r_in;
        chk   = ctl_in.check || (ctl_in.is_div && !ctl_in.div_zero);
        ovf   = chk && ((r_sel < WMIN) || (r_sel > WMAX));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= ctl_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_result_reg   <= ovf ? '0 : r_sel[OPW-1:0];
            m_cond_reg     <= ctl_in.cond;
            m_overflow_reg <= ovf;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_result   = m_result_reg;
    assign m_cond     = m_cond_reg;
    assign m_overflow = m_overflow_reg;

endmodule

### rtl/fixed_point_q24_8_alu_top.sv
// Top level of the signed Q24.8 fixed-point ALU.
// Instantiates fxa_front, a chain of fxa_div_cell and fxa_back; uses fxa_pkg.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  request | s_valid s_ready s_cmd s_operand_a/_b    | in
//  result  | m_valid m_ready m_result m_cond m_overflow | out
//
// One request is taken every cycle while the pipe is not stalled; its result passes through
// fxa_front, the divider chain (one cell per quotient bit) and fxa_back, in that order.
// Every operation runs the same chain, so results keep request order.
// A stall on m_ready freezes the whole pipe; s_ready drops with it.
// Reset clears only the control words of the pipe and the valid bit of the output register.
module fixed_point_q24_8_alu_top #(
    parameter int FRAC_BITS = 8,
    parameter int WORD_BITS = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [3:0]                     s_cmd,
    input  logic signed [fxa_pkg::OPW-1:0] s_operand_a,
    input  logic signed [fxa_pkg::OPW-1:0] s_operand_b,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [fxa_pkg::OPW-1:0] m_result,
    output logic                           m_cond,
    output logic                           m_overflow
);
    import fxa_pkg::*;

    localparam int QW = OPW + FRAC_BITS;

    logic                 en;
    ctl_t                 ctl   [QW+1];
    logic signed [EW-1:0] r     [QW+1];
    logic [QW-1:0]        dq    [QW+1];
    logic [OPW-1:0]       dvs   [QW+1];
    logic [OPW-1:0]       rem   [QW+1];

    // Whole pipe advances when the output register is free or being taken
    assign en      = !m_valid || m_ready;
    assign s_ready = en;
    assign rem[0]  = '0;

    fxa_front #(
        .FRAC_BITS (FRAC_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .s_valid     (s_valid),
        .s_cmd       (s_cmd),
        .s_operand_a (s_operand_a),
        .s_operand_b (s_operand_b),
        .ctl_reg     (ctl[0]),
        .r_reg       (r[0]),
        .dq_reg      (dq[0]),
        .dvs_reg     (dvs[0])
    );

    // Divider chain
    for (genvar i = 0; i < QW; i++) begin : g_cell
        fxa_div_cell #(
            .QW (QW)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .ctl_in  (ctl[i]),
            .r_in    (r[i]),
            .dq_in   (dq[i]),
            .dvs_in  (dvs[i]),
            .rem_in  (rem[i]),
            .ctl_reg (ctl[i+1]),
            .r_reg   (r[i+1]),
            .dq_reg  (dq[i+1]),
            .dvs_reg (dvs[i+1]),
            .rem_reg (rem[i+1])
        );
    end

    fxa_back #(
        .FRAC_BITS (FRAC_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .ctl_in     (ctl[QW]),
        .r_in       (r[QW]),
        .dq_in      (dq[QW]),
        .m_valid    (m_valid),
        .m_result   (m_result),
        .m_cond     (m_cond),
        .m_overflow (m_overflow)
    );

endmodule

### verif/fixed_point_q24_8_alu_top_tb.sv
// Testbench for the signed Q24.8 fixed-point ALU: directed corner requests, then random traffic.
// A local predictor computes each expected result; depends on fxa_pkg and fixed_point_q24_8_alu_top.
`timescale 1ns / 1ps

module fixed_point_q24_8_alu_top_tb;
    import fxa_pkg::*;

    localparam int FRAC       = 8;
    localparam int LATENCY    = 41;
    localparam int IDLE_LIMIT = 5000;

    typedef struct packed {
        logic signed [31:0] value;
        logic               cond;
        logic               ovf;
    } alu_res_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [3:0]         s_cmd = 4'd0;
    logic signed [31:0] s_operand_a = '0;
    logic signed [31:0] s_operand_b = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_result;
    logic               m_cond;
    logic               m_overflow;

    alu_res_t pending_results[$];
    int       mismatch_count = 0;
    int       idle_cycles = 0;
    bit       hold_off = 1'b0;

    fixed_point_q24_8_alu_top dut (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Expected result of one request, worked in 66-bit signed arithmetic
    function automatic alu_res_t predict_alu(alu_op_t op, logic signed [31:0] a,
                                             logic signed [31:0] b);
        logic signed [65:0] wa, wb, r, wmax, wmin;
        alu_res_t res;
        logic check;
        wa = a;
        wb = b;
        wmax = 66'sh7FFF_FFFF;
        wmin = -wmax - 1;
        r = '0;
        check = 1'b0;
        res = '0;
        case (op)
            OP_ADD:  begin r = wa + wb; check = 1'b1; end
            OP_SUB:  begin r = wa - wb; check = 1'b1; end
            OP_MUL:  begin r = (wa * wb) >>> FRAC; check = 1'b1; end
            OP_DIV: begin
                if (wb == 0) r = wa;
                else begin r = (wa <<< FRAC) / wb; check = 1'b1; end
            end
            OP_EQ:   res.cond = (wa == wb);
            OP_NE:   res.cond = (wa != wb);
            OP_LT:   res.cond = (wa < wb);
            OP_GT:   res.cond = (wa > wb);
            OP_LE:   res.cond = (wa <= wb);
            OP_GE:   res.cond = (wa >= wb);
            OP_MIN:  r = (wa > wb) ? wb : wa;
            OP_MAX:  r = (wa > wb) ? wa : wb;
            OP_INC:  r = (wa >= wmax) ? wmin : wa + 1;
            OP_DEC:  r = (wa <= wmin) ? wmax : wa - 1;
            OP_FINT: begin r = wa <<< FRAC; check = 1'b1; end
            default: r = wa >>> FRAC;
        endcase
        if (check && (r > wmax || r < wmin)) begin
            r = '0;
            res.ovf = 1'b1;
        end
        res.value = r[31:0];
        return res;
    endfunction

    // Drive one request and wait for its acceptance
    task automatic send_request(alu_op_t op, logic [31:0] a, logic [31:0] b);
        s_valid     <= 1'b1;
        s_cmd       <= op;
        s_operand_a <= a;
        s_operand_b <= b;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(predict_alu(op, a, b));
        @(negedge aclk);
    endtask

    // Drop valid and wait for a falling clock edge
    task automatic go_idle();
        s_valid <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            1: return 32'h8000_0000 + $urandom_range(0, 3);
            2: return $urandom_range(0, 1023) - 512;
            3: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        logic [31:0] corners[6];
        corners = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h100};
        for (int op = 0; op < 16; op++)
            send_request(alu_op_t'(op), corners[op % 6], corners[(op + 3) % 6]);
        send_request(OP_DIV, 32'h0000_0500, 32'h0);
        send_request(OP_INC, 32'h7FFF_FFFF, 32'h0);
        send_request(OP_DEC, 32'h8000_0000, 32'h0);
        send_request(OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_request(OP_FINT, 32'h0100_0000, 32'h0);
        send_request(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
        go_idle();
    endtask

    // Random bursts with random gaps
    task automatic test_random(int count);
        int sent;
        sent = 0;
        while (sent < count) begin
            for (int i = $urandom_range(1, 20); i > 0 && sent < count; i--) begin
                send_request(alu_op_t'($urandom_range(0, 15)), rand_operand(), rand_operand());
                sent++;
            end
            go_idle();
            if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
    endtask

    // Receiver holds off long enough for the pipe to fill and stall the input
    task automatic test_backpressure();
        hold_off = 1'b1;
        test_random(80);
        hold_off = 1'b0;
    endtask

    // Sender pauses until every expected result has come
    task automatic test_drain();
        test_random(30);
        while (pending_results.size() != 0) @(negedge aclk);
        test_random(30);
    endtask

    // Receiver stall pattern, plus a long hold-off when asked
    initial begin
        int phase;
        phase = 0;
        forever begin
            @(negedge aclk);
            phase++;
            if (hold_off) begin
                m_ready <= 1'b0;
                repeat (150) @(negedge aclk);
                m_ready <= 1'b1;
                wait (!hold_off);
            end else if ((phase / 64) % 2 == 0) m_ready <= 1'b1;
            else m_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Result checker
    always @(posedge aclk) begin
        alu_res_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected result %h", m_result);
            end else begin
                exp_res = pending_results.pop_front();
                if (exp_res.value !== m_result || exp_res.cond !== m_cond
                    || exp_res.ovf !== m_overflow) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %h/%b/%b, got %h/%b/%b",
                                 exp_res.value, exp_res.cond, exp_res.ovf,
                                 m_result, m_cond, m_overflow);
                end
            end
        end
    end

    // Watchdog on cycles with no handshake
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_backpressure();
        test_drain();
        test_random(960);
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (LATENCY + 10) @(negedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
